// ===== rtl/core/tmp_pkg.sv =====
// Package for the trapezoid motion profiler: axis modes, op and register codes,
// and the structs shared by the step logic, the top level and the checker.
// No dependencies.
package tmp_pkg;

    typedef enum logic [1:0]
    {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_HOMING = 2'd2
    } mode_t;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_HOME = 2'd2;

    localparam logic [1:0] REG_TOP_SPEED    = 2'd0;
    localparam logic [1:0] REG_ACCEL_STEP   = 2'd1;
    localparam logic [1:0] REG_SERVO_ENABLE = 2'd2;

    localparam logic [15:0] TOP_SPEED_RESET  = 16'd2000;
    localparam logic [15:0] ACCEL_STEP_RESET = 16'd80;

    localparam int POS_W  = 32;
    localparam int VEL_W  = 17;
    localparam int SPD_W  = 16;
    localparam int RES_W  = POS_W + VEL_W + 2 + 1 + 1;
    localparam int OUT_W  = 56;

    // Bit positions of the result fields inside m_tdata
    localparam int VEL_LSB  = POS_W;
    localparam int MODE_LSB = POS_W + VEL_W;
    localparam int ACC_BIT  = MODE_LSB + 2;
    localparam int DONE_BIT = ACC_BIT + 1;

    typedef struct packed
    {
        logic [15:0] top_speed;
        logic [15:0] accel_step;
        logic        servo_enable;
    } cfg_t;

    typedef struct packed
    {
        logic signed [31:0] position;
        logic signed [31:0] target;
        logic [15:0]        speed_mag;
        logic [15:0]        cruise_limit;
        logic               dir_negative;
        mode_t              mode;
    } axis_state_t;

    // Packed with cur_pos in the lowest bits
    typedef struct packed
    {
        logic               move_done;
        logic               accepted;
        mode_t              axis_mode;
        logic signed [16:0] cur_vel;
        logic signed [31:0] cur_pos;
    } result_t;

endpackage

// ===== rtl/core/tmp_step.sv =====
// Combinational step of the profiler: applies one request to the axis state.
// Depends on tmp_pkg.
module tmp_step
(
    input  logic [1:0]          op,
    input  logic signed [31:0]  target_pos,
    input  logic [15:0]         req_speed,
    input  tmp_pkg::cfg_t       cfg,
    input  tmp_pkg::axis_state_t st,
    output tmp_pkg::axis_state_t st_next,
    output tmp_pkg::result_t    result
);
    import tmp_pkg::*;

    logic [15:0]        lim;
    logic [15:0]        spd_req;
    logic [15:0]        cruise;
    logic signed [31:0] new_target;
    logic signed [32:0] diff;
    logic [32:0]        rem;
    logic [48:0]        prod;
    logic [49:0]        lhs;
    logic [31:0]        rhs;
    logic [16:0]        up;
    logic [15:0]        vnew;
    logic [15:0]        stepv;
    logic [31:0]        pos_new;
    logic [16:0]        vel;
    logic               accepted;
    logic               done;

    always_comb
    begin
        lim        = (cfg.top_speed == 16'd0) ? 16'd1 : cfg.top_speed;
        spd_req    = (op == OP_MOVE) ? req_speed : {1'b0, cfg.top_speed[15:1]};
        cruise     = (spd_req < lim) ? spd_req : lim;
        if (cruise == 16'd0)
        begin
            cruise = 16'd1;
        end
        new_target = (op == OP_MOVE) ? target_pos : 32'sd0;

        diff = {st.target[31], st.target} - {st.position[31], st.position};
        rem  = diff[32] ? 33'(-diff) : 33'(diff);
        prod = {16'd0, cfg.accel_step} * rem;
        lhs  = {prod, 1'b0};
        rhs  = st.speed_mag * st.speed_mag;
        up   = {1'b0, st.speed_mag} + {1'b0, cfg.accel_step};

        if (lhs <= {18'd0, rhs})
        begin
            vnew = (st.speed_mag <= cfg.accel_step) ? 16'd1
                                                    : st.speed_mag - cfg.accel_step;
        end
        else if (st.speed_mag < st.cruise_limit)
        begin
            vnew = (up > {1'b0, st.cruise_limit}) ? st.cruise_limit : up[15:0];
        end
        else
        begin
            vnew = st.speed_mag;
        end
        stepv   = ({17'd0, vnew} < rem) ? vnew : rem[15:0];
        pos_new = st.dir_negative ? st.position - {16'd0, stepv}
                                  : st.position + {16'd0, stepv};

        st_next  = st;
        vel      = 17'd0;
        accepted = 1'b0;
        done     = 1'b0;

        case (op)
            OP_MOVE, OP_HOME:
            begin
                if (cfg.servo_enable)
                begin
                    st_next.target       = new_target;
                    st_next.cruise_limit = cruise;
                    st_next.speed_mag    = 16'd0;
                    st_next.dir_negative = !(new_target > st.position);
                    st_next.mode         = (op == OP_MOVE) ? MODE_MOVING : MODE_HOMING;
                    accepted             = 1'b1;
                end
            end
            default:
            begin
                if (st.mode != MODE_IDLE)
                begin
                    if (rem == 33'd0)
                    begin
                        st_next.position  = st.target;
                        st_next.speed_mag = 16'd0;
                        st_next.mode      = MODE_IDLE;
                        done              = 1'b1;
                    end
                    else
                    begin
                        st_next.speed_mag = vnew;
                        st_next.position  = pos_new;
                        vel = st.dir_negative ? 17'(-{1'b0, vnew}) : {1'b0, vnew};
                    end
                end
            end
        endcase

        result.cur_pos   = st_next.position;
        result.cur_vel   = (st_next.mode == MODE_IDLE) ? 17'sd0 : vel;
        result.axis_mode = st_next.mode;
        result.accepted  = accepted;
        result.move_done = done;
    end

endmodule

// ===== rtl/core/trapezoid_motion_profiler.sv =====
// Trapezoid motion profiler top level: request register, axis state,
// result register and configuration registers. Depends on tmp_pkg, tmp_step.
// Path: request register, combinational step, then result register on m_tdata.
// Throughput: one request per cycle unless the output is stalled by m_tready low.
// Reset: clears axis state to idle at position zero and loads the register
// defaults (top speed 2000, accel_step 80, servo disabled).
module trapezoid_motion_profiler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // target_pos [31:0], req_speed [47:32]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // cur_pos, cur_vel, axis_mode, accepted, move_done, pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import tmp_pkg::*;

    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic signed [31:0] in_target_reg;
    logic [15:0]        in_speed_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    axis_state_t        state_reg;
    axis_state_t        state_next;
    result_t            result_next;
    cfg_t               cfg_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - RES_W)'(0), out_data_reg};

    tmp_step u_step
    (
        .op         (in_op_reg),
        .target_pos (in_target_reg),
        .req_speed  (in_speed_reg),
        .cfg        (cfg_reg),
        .st         (state_reg),
        .st_next    (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_speed    <= TOP_SPEED_RESET;
            cfg_reg.accel_step   <= ACCEL_STEP_RESET;
            cfg_reg.servo_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TOP_SPEED:    cfg_reg.top_speed    <= cfg_wdata;
                REG_ACCEL_STEP:   cfg_reg.accel_step   <= cfg_wdata;
                REG_SERVO_ENABLE: cfg_reg.servo_enable <= cfg_wdata[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{position: '0, target: '0, speed_mag: '0,
                               cruise_limit: '0, dir_negative: 1'b0, mode: MODE_IDLE};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold unless a new request or result moves in
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg     <= s_tuser;
            in_target_reg <= s_tdata[31:0];
            in_speed_reg  <= s_tdata[47:32];
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

endmodule

// ===== rtl/core/tmp_checker.sv =====
// Port-level checker for the trapezoid motion profiler, bound to the top level.
// Depends on tmp_pkg.
module tmp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import tmp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[ACC_BIT] && m_tdata[DONE_BIT]))
        else $error("accepted and move_done both set");

    a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[MODE_LSB+1:MODE_LSB] == MODE_IDLE
            |-> m_tdata[MODE_LSB-1:VEL_LSB] == '0)
        else $error("velocity non-zero while idle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[DONE_BIT] |-> m_tdata[MODE_LSB+1:MODE_LSB] == MODE_IDLE)
        else $error("move_done without returning to idle");

endmodule

bind trapezoid_motion_profiler tmp_checker u_tmp_checker (.*);

// ===== sim/testbench.sv =====
// Testbench for trapezoid_motion_profiler: directed and random move, home and tick
// requests against an in-bench axis predictor, with random stalls on both streams.
// Depends on tmp_pkg and the trapezoid_motion_profiler RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tmp_pkg::*;

    localparam logic [1:0] OP_TICK_ALT = 2'd3;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 300000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = REG_TOP_SPEED;
    logic [15:0] cfg_wdata = '0;

    // predictor state and register copies
    logic [15:0]        cfg_max = TOP_SPEED_RESET;
    logic [15:0]        cfg_accel = ACCEL_STEP_RESET;
    logic               cfg_servo = 1'b0;
    logic signed [31:0] axis_pos = '0;
    logic signed [31:0] axis_target = '0;
    logic [15:0]        speed_mag = '0;
    logic [15:0]        cruise_limit = '0;
    logic               dir_negative = 1'b0;
    mode_t              axis_mode = MODE_IDLE;

    result_t pending_results[$];
    int      requests_sent = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    logic    hold_trigger = 1'b0;
    logic    calm_phase = 1'b0;

    trapezoid_motion_profiler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void load_axis_profile(logic signed [31:0] goal, logic [15:0] spd_req,
                                              mode_t next_mode);
        logic [15:0] lim;
        logic [15:0] c;
        lim = (cfg_max == 16'd0) ? 16'd1 : cfg_max;
        c = (spd_req < lim) ? spd_req : lim;
        if (c == 16'd0)
            c = 16'd1;
        axis_target = goal;
        cruise_limit = c;
        speed_mag = '0;
        dir_negative = (goal > axis_pos) ? 1'b0 : 1'b1;
        axis_mode = next_mode;
    endfunction

    function automatic result_t predict_axis(logic [1:0] op, logic signed [31:0] goal,
                                             logic [15:0] spd_req);
        result_t r;
        longint diff;
        longint rem;
        longint lhs;
        longint rhs;
        longint v;
        longint stepv;
        longint vel;
        r = '0;
        vel = 0;
        if (op == OP_MOVE || op == OP_HOME)
        begin
            if (cfg_servo)
            begin
                if (op == OP_MOVE)
                    load_axis_profile(goal, spd_req, MODE_MOVING);
                else
                    load_axis_profile('0, cfg_max >> 1, MODE_HOMING);
                r.accepted = 1'b1;
            end
        end
        else if (axis_mode != MODE_IDLE)
        begin
            diff = longint'(axis_target) - longint'(axis_pos);
            rem = (diff < 0) ? -diff : diff;
            if (rem == 0)
            begin
                axis_pos = axis_target;
                speed_mag = '0;
                axis_mode = MODE_IDLE;
                r.move_done = 1'b1;
            end
            else
            begin
                lhs = 2 * longint'(cfg_accel) * rem;
                rhs = longint'(speed_mag) * longint'(speed_mag);
                v = longint'(speed_mag);
                if (lhs <= rhs)
                begin
                    v = v - longint'(cfg_accel);
                    if (v < 1)
                        v = 1;
                end
                else if (v < longint'(cruise_limit))
                begin
                    v = v + longint'(cfg_accel);
                    if (v > longint'(cruise_limit))
                        v = longint'(cruise_limit);
                end
                speed_mag = v[15:0];
                stepv = (longint'(speed_mag) < rem) ? longint'(speed_mag) : rem;
                if (dir_negative)
                    axis_pos = 32'(longint'(axis_pos) - stepv);
                else
                    axis_pos = 32'(longint'(axis_pos) + stepv);
                vel = dir_negative ? -longint'(speed_mag) : longint'(speed_mag);
            end
        end
        if (axis_mode == MODE_IDLE)
            vel = 0;
        r.cur_pos = axis_pos;
        r.cur_vel = vel[16:0];
        r.axis_mode = axis_mode;
        return r;
    endfunction

    // Leave s_tvalid high after acceptance; the next call or wait_drained changes it
    task automatic send_item(logic [1:0] op, logic [31:0] goal, logic [15:0] spd_req);
        @(negedge clk);
        while (!calm_phase && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {spd_req, goal};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_axis(op, goal, spd_req));
        requests_sent++;
    endtask

    task automatic send_tick();
        logic [1:0] op;
        op = ($urandom_range(19) == 0) ? OP_TICK_ALT : OP_TICK;
        send_item(op, $urandom, 16'($urandom));
    endtask

    task automatic run_to_target(int cap);
        int n;
        for (n = 0; n < cap && axis_mode != MODE_IDLE; n++)
            send_tick();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_TOP_SPEED:    cfg_max = value;
            REG_ACCEL_STEP:   cfg_accel = value;
            REG_SERVO_ENABLE: cfg_servo = value[0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_profile_regs(logic [15:0] max_spd, logic [15:0] accel, logic servo);
        wait_drained();
        write_reg(REG_TOP_SPEED, max_spd);
        write_reg(REG_ACCEL_STEP, accel);
        write_reg(REG_SERVO_ENABLE, {15'd0, servo});
    endtask

    task automatic test_servo_disabled();
        send_item(OP_MOVE, 32'sd1000, 16'd500);
        send_item(OP_HOME, 32'sd0, 16'd0);
        send_tick();
        send_item(OP_TICK_ALT, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    task automatic test_basic_moves();
        set_profile_regs(TOP_SPEED_RESET, ACCEL_STEP_RESET, 1'b1);
        send_item(OP_MOVE, 32'sd5000, 16'd400);
        run_to_target(200);
        send_tick();
        send_item(OP_MOVE, -32'sd3000, 16'd3000);
        run_to_target(200);
        send_item(OP_HOME, 32'sd0, 16'd0);
        run_to_target(200);
    endtask

    task automatic test_special_cases();
        send_item(OP_MOVE, 32'sd40, 16'd0);
        run_to_target(100);
        send_item(OP_MOVE, 32'sd2000, 16'd300);
        send_item(OP_TICK_ALT, 32'sd0, 16'd0);
        send_tick();
        send_item(OP_MOVE, -32'sd500, 16'd200);
        send_tick();
        send_item(OP_HOME, 32'sd0, 16'd0);
        run_to_target(200);
        send_item(OP_MOVE, axis_pos, 16'd100);
        send_tick();
        set_profile_regs(16'd0, 16'd3, 1'b1);
        send_item(OP_MOVE, axis_pos + 32'sd6, 16'd500);
        run_to_target(50);
        send_item(OP_HOME, 32'sd0, 16'd0);
        run_to_target(50);
        set_profile_regs(16'd65535, 16'd65535, 1'b1);
        send_item(OP_MOVE, 32'h7FFF_FFFF, 16'hFFFF);
        run_to_target(3);
        send_item(OP_MOVE, 32'h8000_0000, 16'hFFFF);
        run_to_target(3);
        send_item(OP_HOME, 32'sd0, 16'd1);
        run_to_target(100);
    endtask

    task automatic test_output_stall();
        int n;
        set_profile_regs(TOP_SPEED_RESET, ACCEL_STEP_RESET, 1'b1);
        calm_phase = 1'b1;
        hold_trigger = 1'b1;
        send_item(OP_MOVE, axis_pos + 32'sd20000, 16'd1500);
        for (n = 0; n < 60; n++)
            send_tick();
        calm_phase = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_motion(int n_items, logic [15:0] max_spd, logic [15:0] accel);
        int stop_at;
        int pick;
        int span;
        int n;
        logic [15:0] spd_req;
        logic [15:0] cruise_est;
        longint goal;
        set_profile_regs(max_spd, accel, 1'b1);
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                spd_req = ($urandom_range(9) < 7) ? 16'($urandom_range(1, 3000))
                                                  : 16'($urandom_range(1, 65535));
                if ($urandom_range(99) < 15)
                begin
                    send_item(OP_HOME, $urandom, 16'($urandom));
                end
                else
                begin
                    cruise_est = (spd_req < max_spd) ? spd_req : max_spd;
                    span = int'(cruise_est) * 30 + 50;
                    if (span > 200000)
                        span = 200000;
                    goal = longint'(axis_pos) + longint'($urandom_range(span))
                           * (($urandom_range(1) == 1) ? 1 : -1);
                    if (goal > 64'sd2147483647)
                        goal = 64'sd2147483647;
                    if (goal < -64'sd2147483648)
                        goal = -64'sd2147483648;
                    send_item(OP_MOVE, goal[31:0], spd_req);
                end
                run_to_target((pick < 70) ? 400 : $urandom_range(1, 30));
                if ($urandom_range(9) < 3)
                    send_tick();
            end
            else if (pick < 90)
            begin
                send_item(2'($urandom_range(3)), $urandom, 16'($urandom));
            end
            else
            begin
                send_item(OP_MOVE, axis_pos + 32'($urandom_range(400)) - 32'sd200,
                          16'($urandom_range(1, 600)));
                for (n = $urandom_range(5); n > 0; n--)
                    send_tick();
                send_item(($urandom_range(1) == 1) ? OP_HOME : OP_MOVE,
                          axis_pos - 32'($urandom_range(100)), 16'($urandom_range(600)));
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_trigger)
        begin
            hold_trigger = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm_phase || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: cur_pos %0d", got.cur_pos);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cur_pos !== want.cur_pos)
                begin
                    $error("cur_pos expected %0d got %0d", want.cur_pos, got.cur_pos);
                    mismatch_count++;
                end
                if (got.cur_vel !== want.cur_vel)
                begin
                    $error("cur_vel expected %0d got %0d", want.cur_vel, got.cur_vel);
                    mismatch_count++;
                end
                if (got.axis_mode !== want.axis_mode)
                begin
                    $error("axis_mode expected %0d got %0d", want.axis_mode, got.axis_mode);
                    mismatch_count++;
                end
                if (got.accepted !== want.accepted)
                begin
                    $error("accepted expected %0d got %0d", want.accepted, got.accepted);
                    mismatch_count++;
                end
                if (got.move_done !== want.move_done)
                begin
                    $error("move_done expected %0d got %0d", want.move_done, got.move_done);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_servo_disabled();
        test_basic_moves();
        test_special_cases();
        test_output_stall();
        test_random_motion(180, TOP_SPEED_RESET, ACCEL_STEP_RESET);
        test_random_motion(180, 16'd65535, 16'd65535);
        calm_phase = 1'b1;
        test_random_motion(180, 16'd1, 16'd1);
        calm_phase = 1'b0;
        test_random_motion(180, 16'd500, 16'd7);
        test_random_motion(180, 16'd300, 16'd300);
        test_random_motion(180, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
